FILE: rtl/core/lzw_pkg.sv
// shared types and constants of the lzw byte compressor
`default_nettype none
package lzw_pkg;
    localparam int DICT_SIZE  = 4096;
    localparam int CODE_W     = $clog2(DICT_SIZE);
    localparam int NFC_W      = CODE_W + 1;
    localparam int OUT_W      = 12;
    localparam int BYTE_W     = 8;
    localparam int FIRST_PAIR = 256;

    typedef struct packed {
        logic [CODE_W-1:0] prefix;
        logic [BYTE_W-1:0] data;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_READ, S_CMP, S_MISS, S_LAST
    } t_state;

    typedef struct packed {
        logic take;
        logic first;
        logic rd;
        logic step;
        logic hit;
        logic emit_miss;
        logic emit_last;
    } t_cmd;

    typedef struct packed {
        logic have;
        logic last;
        logic scan_done;
        logic hit;
        logic out_free;
    } t_stat;
endpackage
`default_nettype wire

FILE: rtl/core/lzw_ctrl.sv
// controller state machine of the lzw byte compressor
`default_nettype none
module lzw_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire lzw_pkg::t_stat i_stat,
    output lzw_pkg::t_cmd      o_cmd
);
    lzw_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lzw_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            lzw_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = lzw_pkg::S_DECIDE;
                end
            end
            lzw_pkg::S_DECIDE: begin
                if (!i_stat.have) begin
                    o_cmd.first = 1'b1;
                    n_state = i_stat.last ? lzw_pkg::S_LAST : lzw_pkg::S_IDLE;
                end else begin
                    n_state = lzw_pkg::S_READ;
                end
            end
            lzw_pkg::S_READ: begin
                if (i_stat.scan_done) begin
                    n_state = lzw_pkg::S_MISS;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = lzw_pkg::S_CMP;
                end
            end
            lzw_pkg::S_CMP: begin
                if (i_stat.hit) begin
                    o_cmd.hit = 1'b1;
                    n_state = i_stat.last ? lzw_pkg::S_LAST : lzw_pkg::S_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = lzw_pkg::S_READ;
                end
            end
            lzw_pkg::S_MISS: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_miss = 1'b1;
                    n_state = i_stat.last ? lzw_pkg::S_LAST : lzw_pkg::S_IDLE;
                end
            end
            lzw_pkg::S_LAST: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_last = 1'b1;
                    n_state = lzw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lzw_pkg::S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

FILE: rtl/core/lzw_dpath.sv
// dictionary memory, match registers and output register of the lzw compressor
`default_nettype none
module lzw_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [lzw_pkg::BYTE_W-1:0]    i_byte,
    input  wire logic                          i_last,
    input  wire lzw_pkg::t_cmd                 i_cmd,
    output lzw_pkg::t_stat                     o_stat,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [lzw_pkg::OUT_W-1:0]          o_out_code,
    output logic                               o_out_last
);
    localparam logic [lzw_pkg::NFC_W-1:0] FIRST = lzw_pkg::NFC_W'(lzw_pkg::FIRST_PAIR);
    localparam logic [lzw_pkg::NFC_W-1:0] FULL  = lzw_pkg::NFC_W'(lzw_pkg::DICT_SIZE);

    lzw_pkg::t_entry r_mem [lzw_pkg::DICT_SIZE];
    lzw_pkg::t_entry r_rd;

    logic [lzw_pkg::CODE_W-1:0] r_cur;
    logic                       r_have;
    logic [lzw_pkg::NFC_W-1:0]  r_nfc;
    logic [lzw_pkg::NFC_W-1:0]  r_scan;
    logic [lzw_pkg::BYTE_W-1:0] r_byte;
    logic                       r_last;
    logic                       r_oval;
    logic [lzw_pkg::OUT_W-1:0]  r_ocode;
    logic                       r_olast;
    logic [lzw_pkg::CODE_W-1:0] w_byte_code;
    logic                       w_ins;

    assign w_byte_code = lzw_pkg::CODE_W'(r_byte);
    assign w_ins       = i_cmd.emit_miss && (r_nfc < FULL);

    assign o_stat.have      = r_have;
    assign o_stat.last      = r_last;
    assign o_stat.scan_done = (r_scan >= r_nfc);
    assign o_stat.hit       = (r_rd.prefix == r_cur) && (r_rd.data == r_byte);
    assign o_stat.out_free  = !r_oval || i_out_ready;

    assign o_out_valid = r_oval;
    assign o_out_code  = r_ocode;
    assign o_out_last  = r_olast;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_scan[lzw_pkg::CODE_W-1:0]];
        end
        if (w_ins) begin
            r_mem[r_nfc[lzw_pkg::CODE_W-1:0]] <= '{prefix: r_cur, data: r_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_byte <= i_byte;
            r_last <= i_last;
        end
        if (i_cmd.emit_miss || i_cmd.emit_last) begin
            r_ocode <= lzw_pkg::OUT_W'(r_cur);
            r_olast <= i_cmd.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_have <= 1'b0;
            r_nfc  <= FIRST;
            r_scan <= FIRST;
            r_oval <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                r_scan <= FIRST;
            end else if (i_cmd.step) begin
                r_scan <= r_scan + 1'b1;
            end
            if (i_cmd.first) begin
                r_cur  <= w_byte_code;
                r_have <= 1'b1;
            end else if (i_cmd.hit) begin
                r_cur <= r_scan[lzw_pkg::CODE_W-1:0];
            end else if (i_cmd.emit_miss) begin
                r_cur <= w_byte_code;
            end else if (i_cmd.emit_last) begin
                r_cur  <= '0;
                r_have <= 1'b0;
            end
            if (i_cmd.emit_last) begin
                r_nfc <= FIRST;
            end else if (w_ins) begin
                r_nfc <= r_nfc + 1'b1;
            end
            if (i_cmd.emit_miss || i_cmd.emit_last) begin
                r_oval <= 1'b1;
            end else if (i_out_ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    a_nfc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nfc >= FIRST) && (r_nfc <= FULL))
        else $error("next free code out of range");
    a_empty_dict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have |-> (r_nfc == FIRST))
        else $error("dictionary not empty between streams");
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_last |=> (!r_have && r_oval && r_olast))
        else $error("final code not flushed");
    a_hit_in_dict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hit |-> (r_scan < r_nfc))
        else $error("match beyond dictionary fill");
endmodule
`default_nettype wire

FILE: rtl/core/lzw_byte_compressor.sv
// top level of the lzw byte compressor
// One byte per input transfer, tlast on the final byte of a stream. Codes go out on
// the master side, tlast on the final code of a stream; a miss on the final byte
// gives two transfers. A byte is taken in S_IDLE and decided in S_DECIDE, then the
// stream's dictionary entries are read in S_READ and compared in S_CMP in order up to
// a match; a miss ends in S_MISS and the final byte passes S_LAST, both waiting while
// the master side holds a waiting code: the dictionary is one single-port memory. The
// first byte of a stream goes from S_DECIDE to S_IDLE, or to S_LAST if it ends the
// stream. The dictionary empties at the end of each stream without a clearing pass;
// entries stop being added once it holds DICT_SIZE codes.
`default_nettype none
module lzw_byte_compressor (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // data_byte
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // code, zero fill
    output logic             o_m_tlast
);
    lzw_pkg::t_cmd             w_cmd;
    lzw_pkg::t_stat            w_stat;
    logic [lzw_pkg::OUT_W-1:0] w_code;

    lzw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    lzw_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_s_tdata),
        .i_last      (i_s_tlast),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_code  (w_code),
        .o_out_last  (o_m_tlast)
    );

    assign o_m_tdata = {4'b0, w_code};
endmodule
`default_nettype wire
